/* sv/shash_pkg.sv */
// ----------------------------------------------------------------------------
// shash_pkg
// Shared types and constants for the streaming SHA-256 hasher: round
// constants, initial hash values, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package shash_pkg;

   localparam int unsigned NumRounds   = 64;
   localparam int unsigned NumHash     = 8;
   localparam int unsigned BlockBits   = 512;
   localparam int unsigned LenPos      = 56;   // first byte slot of the length field

   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam logic [5:0]  FILL_LAST   = 6'd63;
   localparam logic [5:0]  ROUND_LAST  = 6'd63;
   localparam logic [2:0]  WORD_LAST   = 3'd7;

   localparam logic [31:0] K_TABLE [NumRounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV_TABLE [NumHash] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_PAD80,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift;       // push one byte into the block buffer
      byte_sel_type sel;
      logic [7:0]   data_byte;
      logic         count;       // message byte: bump the length
      logic         load_work;   // copy hash words into the working set
      logic         step;        // one compression round
      logic [5:0]   round;
      logic         fold;        // add working set into hash words
      logic [2:0]   word;
      logic         msg_reset;   // back to the initial hash state
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } dp_status_type;

endpackage

/* sv/shash_ctrl.sv */
// ----------------------------------------------------------------------------
// shash_ctrl
// Sequencer for the hasher: byte intake, padding, round count, digest readout.
// ----------------------------------------------------------------------------
module shash_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_kind,
   input  logic [7:0]              req_data_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_word_index,
   output logic                    rsp_last_word,
   output shash_pkg::dp_cmd_type   cmd,
   input  shash_pkg::dp_status_type status
);
   import shash_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       fin_ff, fin_in;          // message end seen, padding under way
   logic       two_blk_ff, two_blk_in;  // length must wait for the next block
   logic       len_ff, len_in;          // length written into this block

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         round_ff   <= '0;
         word_ff    <= '0;
         fin_ff     <= 1'b0;
         two_blk_ff <= 1'b0;
         len_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         round_ff   <= round_in;
         word_ff    <= word_in;
         fin_ff     <= fin_in;
         two_blk_ff <= two_blk_in;
         len_ff     <= len_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      word_in    = word_ff;
      fin_in     = fin_ff;
      two_blk_in = two_blk_ff;
      len_in     = len_ff;

      cmd            = '0;
      cmd.sel        = SEL_DATA;
      cmd.data_byte  = req_data_byte;
      cmd.round      = round_ff;
      cmd.word       = word_ff;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.shift = 1'b1;
               if (!req_kind) begin
                  cmd.sel   = SEL_DATA;
                  cmd.count = 1'b1;
               end else begin
                  cmd.sel    = SEL_PAD80;
                  fin_in     = 1'b1;
                  // pad byte landing in the length slots pushes length out a block
                  two_blk_in = (status.fill >= 6'(LenPos));
                  state_in   = ST_PAD;
               end
               if (status.fill == FILL_LAST) begin
                  cmd.load_work = 1'b1;
                  two_blk_in    = 1'b0;
                  round_in      = '0;
                  state_in      = ST_ROUND;
               end
            end
         end
         ST_PAD: begin
            cmd.shift = 1'b1;
            if (two_blk_ff || status.fill < 6'(LenPos)) begin
               cmd.sel = SEL_ZERO;
            end else begin
               cmd.sel = SEL_LEN;
               len_in  = 1'b1;
            end
            if (status.fill == FILL_LAST) begin
               cmd.load_work = 1'b1;
               two_blk_in    = 1'b0;
               round_in      = '0;
               state_in      = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.step = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (fin_ff && len_ff) begin
               word_in  = '0;
               state_in = ST_EMIT;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (word_ff == WORD_LAST) begin
                  cmd.msg_reset = 1'b1;
                  fin_in        = 1'b0;
                  len_in        = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_word_index = word_ff;
   assign rsp_last_word  = (word_ff == WORD_LAST);

endmodule

/* sv/shash_datapath.sv */
// ----------------------------------------------------------------------------
// shash_datapath
// Block buffer / message schedule, round logic, hash words and length count.
// ----------------------------------------------------------------------------
module shash_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  shash_pkg::dp_cmd_type    cmd,
   output shash_pkg::dp_status_type status,
   output logic [31:0]              rsp_digest_word
);
   import shash_pkg::*;

   // byte 0 of the block sits at the top once the buffer is full; during
   // rounds the same register runs as the 16-word schedule window
   logic [BlockBits-1:0] buf_ff, buf_in;
   logic [31:0]          hash_ff [NumHash];
   logic [31:0]          work_ff [NumHash];
   logic [5:0]           fill_ff;
   logic [60:0]          bytes_ff;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] sum0, sum1, ch, maj, t1, t2;
   logic [63:0] bit_len;
   logic [7:0]  len_byte, push_byte;

   assign w0  = buf_ff[511:480];
   assign w1  = buf_ff[479:448];
   assign w9  = buf_ff[223:192];
   assign w14 = buf_ff[63:32];

   assign w_new = (ror32(w14, 17) ^ ror32(w14, 19) ^ (w14 >> 10)) + w9
                + (ror32(w1, 7) ^ ror32(w1, 18) ^ (w1 >> 3)) + w0;

   assign sum1 = ror32(work_ff[4], 6) ^ ror32(work_ff[4], 11) ^ ror32(work_ff[4], 25);
   assign ch   = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign t1   = work_ff[7] + sum1 + ch + K_TABLE[cmd.round] + w0;
   assign sum0 = ror32(work_ff[0], 2) ^ ror32(work_ff[0], 13) ^ ror32(work_ff[0], 22);
   assign maj  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
               ^ (work_ff[1] & work_ff[2]);
   assign t2   = sum0 + maj;

   // length goes out big-endian, one byte per slot from 56 up
   assign bit_len  = {bytes_ff, 3'b000};
   assign len_byte = bit_len[(7 - fill_ff[2:0]) * 8 +: 8];

   always_comb begin
      case (cmd.sel)
         SEL_DATA:  push_byte = cmd.data_byte;
         SEL_PAD80: push_byte = PAD_BYTE;
         SEL_LEN:   push_byte = len_byte;
         default:   push_byte = 8'h00;
      endcase
   end

   always_comb begin
      buf_in = buf_ff;
      if (cmd.shift) begin
         buf_in = {buf_ff[BlockBits-9:0], push_byte};
      end else if (cmd.step) begin
         buf_in = {buf_ff[BlockBits-33:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         for (int i = 0; i < NumHash; i++) begin
            work_ff[i] <= hash_ff[i];
         end
      end else if (cmd.step) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.msg_reset) begin
         for (int i = 0; i < NumHash; i++) begin
            hash_ff[i] <= IV_TABLE[i];
         end
         fill_ff  <= '0;
         bytes_ff <= '0;
      end else begin
         if (cmd.fold) begin
            for (int i = 0; i < NumHash; i++) begin
               hash_ff[i] <= hash_ff[i] + work_ff[i];
            end
         end
         if (cmd.shift) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (cmd.count) begin
            bytes_ff <= bytes_ff + 61'd1;
         end
      end
   end

   assign status.fill     = fill_ff;
   assign rsp_digest_word = hash_ff[cmd.word];

endmodule

/* sv/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream; an end item pads the message and reads out
// the eight digest words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_kind, req_data_byte
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_digest_word, rsp_word_index,
//          |           |                        | rsp_last_word
//
// A data byte is pushed into the block buffer; the 64th byte of a block starts
// the 64 rounds (one per cycle on the round unit), then the hash add.
// An end item pushes pad and length bytes one per cycle, compresses one or
// two blocks, then presents the eight digest words, one per accepted cycle.
// req_stall is high from the block-fill until the block is folded in, and
// through padding and readout. Synchronous reset restores the initial hash.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import shash_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   shash_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd),
      .status         (status)
   );

   shash_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule
